/* hdl/wccs_pkg.sv */
// ----------------------------------------------------------------------------
// wccs_pkg
// shared types and constants of the weighted cost channel selector
// ----------------------------------------------------------------------------
package wccs_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_LIMIT_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_LIMIT_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_CAP_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_CAP_B = 3'd4;

  localparam logic [1:0] MODE_RR    = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_COST  = 2'd2;

  localparam logic [1:0] RESET_MODE = MODE_COST;
  localparam int RESET_RTT_LIMIT_A = 11000;
  localparam int RESET_RTT_LIMIT_B = 51000;
  localparam int RESET_CAP_A       = 480;
  localparam int RESET_CAP_B       = 500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_RUN,
    ST_COST,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic cap;
    logic div_load;
    logic div_step;
    logic cost_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic div_all;
  } sts_t;

endpackage

/* hdl/wccs_ctrl.sv */
// ----------------------------------------------------------------------------
// wccs_ctrl
// sequencer: capture, four shared divisions when needed, cost, decision, output word
// ----------------------------------------------------------------------------
module wccs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  wccs_pkg::sts_t  sts,
  output wccs_pkg::cmd_t  cmd
);

  wccs_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wccs_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = wccs_pkg::ST_SETUP;
      end
      wccs_pkg::ST_SETUP: begin
        state_nxt = sts.need_div ? wccs_pkg::ST_LOAD : wccs_pkg::ST_DECIDE;
      end
      wccs_pkg::ST_LOAD: begin
        state_nxt = wccs_pkg::ST_RUN;
      end
      wccs_pkg::ST_RUN: begin
        if (sts.div_last) state_nxt = sts.div_all ? wccs_pkg::ST_COST : wccs_pkg::ST_LOAD;
      end
      wccs_pkg::ST_COST: begin
        state_nxt = wccs_pkg::ST_DECIDE;
      end
      wccs_pkg::ST_DECIDE: begin
        if (out_free) state_nxt = wccs_pkg::ST_IDLE;
      end
      default: state_nxt = wccs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      wccs_pkg::ST_IDLE:   cmd.cap      = in_tvalid;
      wccs_pkg::ST_SETUP:  cmd          = '0;
      wccs_pkg::ST_LOAD:   cmd.div_load = 1'b1;
      wccs_pkg::ST_RUN:    cmd.div_step = 1'b1;
      wccs_pkg::ST_COST:   cmd.cost_en  = 1'b1;
      wccs_pkg::ST_DECIDE: cmd.out_load = out_free;
      default:             cmd          = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wccs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == wccs_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* hdl/wccs_dp.sv */
// ----------------------------------------------------------------------------
// wccs_dp
// datapath: settings, item capture, shared restoring divider, costs, result
// ----------------------------------------------------------------------------
module wccs_dp #(
  parameter int RATIO_FRAC_BITS = 16,
  parameter int FIELD_BITS      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wccs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [FIELD_BITS-1:0]                cfg_wdata,
  input  logic [((4*FIELD_BITS+4+7)/8)*8-1:0]  in_tdata,
  input  wccs_pkg::cmd_t                       cmd,
  output wccs_pkg::sts_t                       sts,
  output logic [wccs_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int F  = FIELD_BITS;
  localparam int R  = RATIO_FRAC_BITS;
  localparam int QW = R + 1;
  localparam int KW = R + 4;
  localparam int CW = $clog2(R + 1);
  localparam logic [QW-1:0] RATIO_MAX = {QW{1'b1}};
  localparam logic [QW-1:0] RATIO_ONE = {1'b1, {R{1'b0}}};

  logic [1:0]   mode_r;
  logic [F-1:0] lim_a_r, lim_b_r, cap_a_r, cap_b_r;

  logic [1:0]   prio_r;
  logic [F-1:0] rtt_a_r, rtt_b_r, load_a_r, load_b_r;
  logic         full_a_r, full_b_r;
  logic         rr_r;

  logic [1:0]    div_idx_r;
  logic [CW-1:0] cnt_r;
  logic [F:0]    rem_r;
  logic [R-1:0]  q_r;
  logic          sat_r;
  logic [QW-1:0] sat_val_r;
  logic [QW-1:0] ratio_r [4];
  logic [KW-1:0] cost_a_r, cost_b_r;
  logic          out_ch_r, out_acc_r;

  logic [F-1:0]  num, den;
  logic [QW-1:0] zero_val;
  logic          ovf, ge, last;
  logic [F:0]    diff;
  logic [2:0]    w_rtt, w_load;
  logic          dec_ch;

  // operand selection for the shared divider
  always_comb begin
    case (div_idx_r)
      2'd0: begin
        num = rtt_a_r;  den = lim_a_r; zero_val = RATIO_MAX;
      end
      2'd1: begin
        num = load_a_r; den = cap_a_r; zero_val = RATIO_ONE;
      end
      2'd2: begin
        num = rtt_b_r;  den = lim_b_r; zero_val = RATIO_MAX;
      end
      default: begin
        num = load_b_r; den = cap_b_r; zero_val = RATIO_ONE;
      end
    endcase
  end

  // quotient exceeds the Q1 range exactly when num >= 2 * den
  assign ovf  = {1'b0, num} >= {den, 1'b0};
  assign ge   = rem_r >= {1'b0, den};
  assign diff = rem_r - (ge ? {1'b0, den} : {(F+1){1'b0}});
  assign last = (cnt_r == CW'(R));

  assign w_rtt  = {1'b0, prio_r} + 3'd1;
  assign w_load = 3'd4 - {1'b0, prio_r};

  always_comb begin
    if (prio_r == 2'd0) begin
      dec_ch = 1'b0;
    end else begin
      case (mode_r)
        wccs_pkg::MODE_RR:    dec_ch = rr_r;
        wccs_pkg::MODE_FIXED: dec_ch = 1'b1;
        default:              dec_ch = !(cost_a_r < cost_b_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= wccs_pkg::RESET_MODE;
      lim_a_r <= F'(wccs_pkg::RESET_RTT_LIMIT_A);
      lim_b_r <= F'(wccs_pkg::RESET_RTT_LIMIT_B);
      cap_a_r <= F'(wccs_pkg::RESET_CAP_A);
      cap_b_r <= F'(wccs_pkg::RESET_CAP_B);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wccs_pkg::CFG_POLICY_MODE:  mode_r  <= cfg_wdata[1:0];
        wccs_pkg::CFG_RTT_LIMIT_A:  lim_a_r <= cfg_wdata;
        wccs_pkg::CFG_RTT_LIMIT_B:  lim_b_r <= cfg_wdata;
        wccs_pkg::CFG_USABLE_CAP_A: cap_a_r <= cfg_wdata;
        wccs_pkg::CFG_USABLE_CAP_B: cap_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r      <= 1'b0;
      div_idx_r <= 2'd0;
      cnt_r     <= '0;
    end else begin
      if (cmd.cap) div_idx_r <= 2'd0;
      if (cmd.div_load) cnt_r <= '0;
      if (cmd.div_step) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) div_idx_r <= div_idx_r + 2'd1;
      end
      if (cmd.out_load && prio_r != 2'd0 && mode_r == wccs_pkg::MODE_RR) rr_r <= !rr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      prio_r   <= in_tdata[1:0];
      rtt_a_r  <= in_tdata[F+1:2];
      rtt_b_r  <= in_tdata[2*F+1:F+2];
      load_a_r <= in_tdata[3*F+1:2*F+2];
      load_b_r <= in_tdata[4*F+1:3*F+2];
      full_a_r <= in_tdata[4*F+2];
      full_b_r <= in_tdata[4*F+3];
    end
    if (cmd.div_load) begin
      rem_r     <= {1'b0, num};
      q_r       <= '0;
      sat_r     <= ovf || (den == '0);
      sat_val_r <= (den == '0) ? zero_val : RATIO_MAX;
    end
    if (cmd.div_step) begin
      rem_r <= {diff[F-1:0], 1'b0};
      q_r   <= {q_r[R-2:0], ge};
      if (last) ratio_r[div_idx_r] <= sat_r ? sat_val_r : {q_r, ge};
    end
    if (cmd.cost_en) begin
      cost_a_r <= KW'(w_rtt) * KW'(ratio_r[0]) + KW'(w_load) * KW'(ratio_r[1]);
      cost_b_r <= KW'(w_rtt) * KW'(ratio_r[2]) + KW'(w_load) * KW'(ratio_r[3]);
    end
    if (cmd.out_load) begin
      out_ch_r  <= dec_ch;
      out_acc_r <= dec_ch ? !full_b_r : !full_a_r;
    end
  end

  assign sts.need_div = (prio_r != 2'd0) && (mode_r != wccs_pkg::MODE_RR)
                        && (mode_r != wccs_pkg::MODE_FIXED);
  assign sts.div_last = last;
  assign sts.div_all  = (div_idx_r == 2'd3);

  assign out_tdata = wccs_pkg::OUT_TDATA_W'({out_acc_r, out_ch_r});

endmodule

/* hdl/weighted_cost_channel_selector.sv */
// ----------------------------------------------------------------------------
// weighted_cost_channel_selector
// picks channel A or B for the packet at the head of the send list
//
//   channel  dir  word fields (lowest bit up)
//   in_      in   priority_req, rtt_a, rtt_b, load_a, load_b, full_a, full_b
//   out_     out  chosen_channel, accepted
//   cfg_     in   policy_mode, rtt_limit_a/b, usable_capacity_a/b by index
//
// one word at a time; cost mode with nonzero priority runs four divisions
//   through the one bit-per-cycle divider, then the cost step and the
//   decision; other words go from setup straight to the decision
// a finished word waits in the output register while the next is taken in
// synchronous active-low reset; no clearing pass
// ----------------------------------------------------------------------------
module weighted_cost_channel_selector #(
  parameter int RATIO_FRAC_BITS = 16,
  parameter int FIELD_BITS      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // priority_req, rtt_a, rtt_b, load_a, load_b, full_a, full_b, zero pad
  input  logic [((4*FIELD_BITS+4+7)/8)*8-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // chosen_channel, accepted, zero pad
  output logic [wccs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [wccs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [FIELD_BITS-1:0]                cfg_wdata
);

  wccs_pkg::cmd_t cmd;
  wccs_pkg::sts_t sts;

  wccs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wccs_dp #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .FIELD_BITS      (FIELD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

/* hdl/wccs_chk.sv */
// ----------------------------------------------------------------------------
// wccs_chk
// port-level checks of the channel selector, bound to the top level
// ----------------------------------------------------------------------------
module wccs_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [wccs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [1:0] pend_r, pend_nxt;
  logic in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // words taken in but not yet delivered
  always_comb begin
    pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken again while a word is in work");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("output word without an input word");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two words outstanding");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind weighted_cost_channel_selector wccs_chk u_wccs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
